[rtl/swiglu_sparsity_reduce_assert.svh]
// Assertion macros for the SwiGLU sparsity reduce block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SWIGLU_SPARSITY_REDUCE_ASSERT_SVH
`define SWIGLU_SPARSITY_REDUCE_ASSERT_SVH
`ifndef SYNTHESIS
`define SWR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("swiglu_sparsity_reduce: assertion failed");
`define SWR_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("swiglu_sparsity_reduce: forbidden condition seen");
`else
`define SWR_ASSERT(label, clk, rst, prop)
`define SWR_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

[rtl/swr_pkg.sv]
// Shared constants, types and sigmoid table functions of the SwiGLU sparsity block.
// Has no dependencies; the interfaces, swr_ctrl, swr_datapath, the top level and the testbench import it.
`default_nettype none

package swr_pkg;

   localparam int unsigned SWR_MAX_CHANNELS    = 16384;
   localparam int unsigned SWR_SIGMOID_ENTRIES = 1024;

   localparam int unsigned VAL_W = 16;
   localparam int unsigned ACT_W = 18;
   localparam int unsigned IDX_W = 14;
   localparam int unsigned CNT_W = 15;

   typedef struct packed {
      logic capture;
      logic mul_first;
      logic finish;
   } swr_cmd_type;

   // Unsigned division by shift and subtract, used only while building the table.
   function automatic longint unsigned swr_udiv(input longint unsigned num,
                                                input longint unsigned den);
      longint unsigned rem;
      longint unsigned quo;
      rem = 0;
      quo = 0;
      for (int i = 63; i >= 0; i--) begin
         rem = (rem << 1) | longint'(num[i]);
         if (rem >= den) begin
            rem = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Returns e^-(m/4096) in Q31 for m in 0 to 32768.
   function automatic longint unsigned swr_exp_neg_q31(input longint unsigned m);
      longint unsigned f;
      longint unsigned term;
      longint sum;
      longint unsigned r;
      f = m << 15;
      term = 64'd2147483648;
      sum = longint'(term);
      for (int k = 1; k <= 20; k++) begin
         term = swr_udiv((term * f) >> 31, longint'(k));
         if ((k % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > 64'sd2147483648) begin
         sum = 64'sd2147483648;
      end
      r = longint'(sum);
      for (int i = 0; i < 4; i++) begin
         r = (r * r + 64'd1073741824) >> 31;
      end
      return r;
   endfunction

   // Sigmoid sample of table entry k, unsigned Q0.16, for a table of the given size.
   function automatic logic [15:0] swr_sigmoid_entry(input int unsigned k,
                                                     input int unsigned entries);
      longint unsigned off;
      longint unsigned mag;
      longint unsigned den;
      longint unsigned s;
      logic            neg;
      off = swr_udiv((2 * longint'(k) + 1) * 32768, longint'(entries));
      neg = (off < 32768);
      mag = neg ? (64'd32768 - off) : (off - 64'd32768);
      den = 64'd2147483648 + swr_exp_neg_q31(mag);
      s = swr_udiv((64'd1 << 47) + (den >> 1), den);
      if (neg) begin
         s = 64'd65536 - s;
      end
      if (s > 64'd65535) begin
         s = 64'd65535;
      end
      return s[15:0];
   endfunction

endpackage

`default_nettype wire

[rtl/swr_req_if.sv]
// Request channel of the SwiGLU sparsity block: one channel of a token per request.
// Uses the widths of swr_pkg.
`default_nettype none

interface swr_req_if import swr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] gate_value;
   logic signed [VAL_W-1:0] up_value;
   logic                    last_channel;

   modport source (output valid, output gate_value, output up_value,
                   output last_channel, input ready);
   modport sink (input valid, input gate_value, input up_value,
                 input last_channel, output ready);
endinterface

`default_nettype wire

[rtl/swr_rsp_if.sv]
// Response channel of the SwiGLU sparsity block: one result per channel.
// Uses the widths of swr_pkg.
`default_nettype none

interface swr_rsp_if import swr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] abs_activation;
   logic             fired;
   logic [IDX_W-1:0] channel_index;
   logic [CNT_W-1:0] fired_count;
   logic             token_done;

   modport source (output valid, output abs_activation, output fired,
                   output channel_index, output fired_count, output token_done,
                   input ready);
   modport sink (input valid, input abs_activation, input fired,
                 input channel_index, input fired_count, input token_done,
                 output ready);
endinterface

`default_nettype wire

[rtl/swr_csr_if.sv]
// Configuration write channel of the SwiGLU sparsity block, carrying the threshold.
// Uses the widths of swr_pkg.
`default_nettype none

interface swr_csr_if import swr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] eps_threshold;

   modport source (output valid, output eps_threshold, input ready);
   modport sink (input valid, input eps_threshold, output ready);
endinterface

`default_nettype wire

[rtl/swr_ctrl.sv]
// Controller of the SwiGLU sparsity block: sequences capture, two multiplies and output.
// Depends on swr_pkg for the command struct.
`default_nettype none

module swr_ctrl import swr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output swr_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MUL1 = 3'b010,
      S_MUL2 = 3'b100
   } swr_state_type;

   swr_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   logic          slot_free;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd.capture   = 1'b0;
      cmd.mul_first = 1'b0;
      cmd.finish    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_first = 1'b1;
            state_in      = S_MUL2;
         end
         S_MUL2: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

[rtl/swr_datapath.sv]
// Datapath of the SwiGLU sparsity block: sigmoid ROM, shared multiplier, counters.
// Depends on swr_pkg for widths, the command struct and the table function.
`default_nettype none

module swr_datapath import swr_pkg::*; #(
   parameter int unsigned MAX_CHANNELS    = SWR_MAX_CHANNELS,
   parameter int unsigned SIGMOID_ENTRIES = SWR_SIGMOID_ENTRIES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  swr_cmd_type             cmd,
   input  logic signed [VAL_W-1:0] gate_value,
   input  logic signed [VAL_W-1:0] up_value,
   input  logic                    last_channel,
   input  logic                    csr_write,
   input  logic [ACT_W-1:0]        csr_eps_threshold,
   output logic [ACT_W-1:0]        abs_activation,
   output logic                    fired,
   output logic [IDX_W-1:0]        channel_index,
   output logic [CNT_W-1:0]        fired_count,
   output logic                    token_done
);

   localparam int unsigned ROM_AW = (SIGMOID_ENTRIES > 1) ? $clog2(SIGMOID_ENTRIES) : 1;
   localparam int unsigned NW     = $clog2(SIGMOID_ENTRIES + 1);
   localparam int unsigned PW     = VAL_W + NW;
   localparam int unsigned MW     = $clog2(MAX_CHANNELS + 1);

   logic [15:0] rom_w [SIGMOID_ENTRIES];

   genvar g;
   for (g = 0; g < SIGMOID_ENTRIES; g++) begin : g_rom
      localparam logic [15:0] ENTRY = swr_sigmoid_entry(g, SIGMOID_ENTRIES);
      assign rom_w[g] = ENTRY;
   end

   logic [VAL_W-1:0]  gate_off;
   logic [PW-1:0]     idx_prod;
   logic [NW-1:0]     idx_full;
   logic [ROM_AW-1:0] rom_addr;
   logic [VAL_W-1:0]  gate_mag, up_mag;

   assign gate_off = {~gate_value[VAL_W-1], gate_value[VAL_W-2:0]};
   assign idx_prod = PW'(gate_off) * PW'(SIGMOID_ENTRIES);
   assign idx_full = idx_prod[PW-1:VAL_W];
   assign rom_addr = (idx_full > NW'(SIGMOID_ENTRIES - 1)) ?
                     ROM_AW'(SIGMOID_ENTRIES - 1) : ROM_AW'(idx_full);
   assign gate_mag = gate_value[VAL_W-1] ? (~gate_value + 1'b1) : gate_value;
   assign up_mag   = up_value[VAL_W-1] ? (~up_value + 1'b1) : up_value;

   logic [VAL_W-1:0] gmag_ff, umag_ff, rom_ff, smag_ff;
   logic             last_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         gmag_ff <= gate_mag;
         umag_ff <= up_mag;
         last_ff <= last_channel;
         rom_ff  <= rom_w[rom_addr];
      end
   end

   logic [15:0] mul_a, mul_b;
   logic [31:0] mul_p;
   logic [32:0] smag_sum, act_sum;
   logic [20:0] act_full;
   logic [ACT_W-1:0] act_sat;

   assign mul_a    = cmd.mul_first ? gmag_ff : smag_ff;
   assign mul_b    = cmd.mul_first ? rom_ff : umag_ff;
   assign mul_p    = mul_a * mul_b;
   assign smag_sum = {1'b0, mul_p} + 33'd32768;
   assign act_sum  = {1'b0, mul_p} + 33'd2048;
   assign act_full = act_sum[32:12];
   assign act_sat  = (act_full[20:ACT_W] != '0) ? {ACT_W{1'b1}} : act_full[ACT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mul_first) begin
         smag_ff <= smag_sum[31:16];
      end
   end

   logic [ACT_W-1:0] eps_ff;
   logic [IDX_W-1:0] chan_ff, chan_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic             fire_now;
   logic [CNT_W:0]   count_full;
   logic [CNT_W-1:0] count_sat;
   logic [IDX_W:0]   chan_inc;

   assign fire_now   = act_sat > eps_ff;
   assign count_full = {1'b0, total_ff} + {{CNT_W{1'b0}}, fire_now};
   assign count_sat  = count_full[CNT_W] ? {CNT_W{1'b1}} : count_full[CNT_W-1:0];
   assign chan_inc   = {1'b0, chan_ff} + 1'b1;

   always_comb begin
      if (last_ff) begin
         chan_in  = '0;
         total_in = '0;
      end else begin
         total_in = count_sat;
         if ((MW + 1)'(chan_inc) == (MW + 1)'(MAX_CHANNELS)) begin
            chan_in = '0;
         end else begin
            chan_in = chan_inc[IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff   <= '0;
         chan_ff  <= '0;
         total_ff <= '0;
      end else begin
         if (csr_write) begin
            eps_ff <= csr_eps_threshold;
         end
         if (cmd.finish) begin
            chan_ff  <= chan_in;
            total_ff <= total_in;
         end
      end
   end

   logic [ACT_W-1:0] act_ff;
   logic             fired_ff, done_ff;
   logic [IDX_W-1:0] index_ff;
   logic [CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         act_ff   <= act_sat;
         fired_ff <= fire_now;
         index_ff <= chan_ff;
         count_ff <= count_sat;
         done_ff  <= last_ff;
      end
   end

   assign abs_activation = act_ff;
   assign fired          = fired_ff;
   assign channel_index  = index_ff;
   assign fired_count    = count_ff;
   assign token_done     = done_ff;

endmodule

`default_nettype wire

[rtl/swiglu_sparsity_reduce.sv]
// A request is taken only while idle. The registered sigmoid ROM is read at acceptance,
// then one shared 16 by 16 multiplier is used twice, first for gate times sigmoid and
// then for the result times up, and the threshold compare with the second product. A
// finished result sits in an output register, so the next request is taken while it
// waits; the block stalls only when a result is ready and that register is still full.
// The user must write the threshold through the configuration channel while idle; the
// block does not enforce it. Top level of the SwiGLU sparsity block; uses swr_pkg, the
// channel interfaces, swr_ctrl, swr_datapath and the assertion macro header.
`default_nettype none
`include "swiglu_sparsity_reduce_assert.svh"

module swiglu_sparsity_reduce import swr_pkg::*; #(
   parameter int unsigned MAX_CHANNELS    = SWR_MAX_CHANNELS,
   parameter int unsigned SIGMOID_ENTRIES = SWR_SIGMOID_ENTRIES
) (
   input  logic      clock,
   input  logic      reset,
   swr_req_if.sink   req_chan,
   swr_rsp_if.source rsp_chan,
   swr_csr_if.sink   csr_chan
);

   swr_cmd_type cmd;

   assign csr_chan.ready = 1'b1;

   swr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   swr_datapath #(
      .MAX_CHANNELS    (MAX_CHANNELS),
      .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .gate_value        (req_chan.gate_value),
      .up_value          (req_chan.up_value),
      .last_channel      (req_chan.last_channel),
      .csr_write         (csr_chan.valid),
      .csr_eps_threshold (csr_chan.eps_threshold),
      .abs_activation    (rsp_chan.abs_activation),
      .fired             (rsp_chan.fired),
      .channel_index     (rsp_chan.channel_index),
      .fired_count       (rsp_chan.fired_count),
      .token_done        (rsp_chan.token_done)
   );

   `SWR_ASSERT(a_busy_after_accept, clock, reset, (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
   `SWR_ASSERT(a_multiply_follows_accept, clock, reset, (req_chan.valid && req_chan.ready) |=> cmd.mul_first)
   `SWR_ASSERT_NEVER(a_no_overwrite, clock, reset, cmd.finish && rsp_chan.valid && !rsp_chan.ready)

endmodule

`default_nettype wire

[dv/swiglu_sparsity_reduce_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for swiglu_sparsity_reduce: a directed table, then random tokens
// and one longer token in which every channel fires, checked against a local predictor
// or typed rows. Depends on swr_pkg, swr_req_if, swr_rsp_if, swr_csr_if and the block.

module swiglu_sparsity_reduce_tb;
   import swr_pkg::*;

   localparam longint unsigned ACT_MAX   = (64'd1 << ACT_W) - 1;
   localparam longint unsigned CNT_MAX   = (64'd1 << CNT_W) - 1;
   localparam int unsigned     IDX_MASK  = (1 << IDX_W) - 1;
   localparam int              GAP_MAX   = 17;
   localparam int              HOLD_LEN  = 400;
   localparam int              LONG_LEN  = 64;
   localparam int              PRINT_CAP = 100;

   typedef struct packed {
      logic [ACT_W-1:0] abs_activation;
      logic             fired;
      logic [IDX_W-1:0] channel_index;
      logic [CNT_W-1:0] fired_count;
      logic             token_done;
   } channel_result_type;

   typedef struct packed {
      logic [VAL_W-1:0]   gate;
      logic [VAL_W-1:0]   up;
      logic               last;
      logic               typed;
      channel_result_type want;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 20;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{16'h0000, 16'h0000, 1'b0, 1'b1, '{18'd0, 1'b0, 14'd0, 15'd0, 1'b0}},
      '{16'h0000, 16'h7FFF, 1'b0, 1'b1, '{18'd0, 1'b0, 14'd1, 15'd0, 1'b0}},
      '{16'h8000, 16'h0000, 1'b0, 1'b1, '{18'd0, 1'b0, 14'd2, 15'd0, 1'b0}},
      '{16'h7FFF, 16'h0000, 1'b0, 1'b1, '{18'd0, 1'b0, 14'd3, 15'd0, 1'b0}},
      '{16'h0000, 16'h8000, 1'b0, 1'b1, '{18'd0, 1'b0, 14'd4, 15'd0, 1'b0}},
      '{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, '0},
      '{16'h7FFF, 16'h8000, 1'b0, 1'b0, '0},
      '{16'h8000, 16'h7FFF, 1'b0, 1'b0, '0},
      '{16'h8000, 16'h8000, 1'b0, 1'b0, '0},
      '{16'h0001, 16'h0001, 1'b0, 1'b0, '0},
      '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0},
      '{16'h1000, 16'h1000, 1'b0, 1'b0, '0},
      '{16'hF000, 16'h1000, 1'b0, 1'b0, '0},
      '{16'h2000, 16'hF000, 1'b0, 1'b0, '0},
      '{16'h7FC0, 16'h4000, 1'b0, 1'b0, '0},
      '{16'h8040, 16'hC000, 1'b1, 1'b0, '0},
      '{16'h0000, 16'h0000, 1'b1, 1'b1, '{18'd0, 1'b0, 14'd0, 15'd0, 1'b1}},
      '{16'h0000, 16'h7FFF, 1'b1, 1'b1, '{18'd0, 1'b0, 14'd0, 15'd0, 1'b1}},
      '{16'h4000, 16'h4000, 1'b0, 1'b0, '0},
      '{16'hFFC0, 16'h7FFF, 1'b1, 1'b0, '0}
   };

   logic clock;
   logic reset;

   swr_req_if req_bus ();
   swr_rsp_if rsp_bus ();
   swr_csr_if csr_bus ();

   swiglu_sparsity_reduce dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   logic [15:0]        sigmoid_table [SWR_SIGMOID_ENTRIES];
   logic [ACT_W-1:0]   threshold_reg;
   int unsigned        chan_pos;
   int unsigned        fired_so_far;
   channel_result_type expected_results [$];
   int                 mismatches;
   bit                 source_idles;
   bit                 sink_idles;
   bit                 hold_sink;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   // e^-(m/4096) in Q31 from a truncated Taylor series, then squared four times.
   function automatic longint unsigned neg_exp_q31(input longint unsigned m);
      longint unsigned x;
      longint unsigned term;
      longint unsigned r;
      longint          acc;
      x = m << 15;
      term = 64'd1 << 31;
      acc = longint'(term);
      for (int k = 1; k <= 20; k++) begin
         term = ((term * x) >> 31) / longint'(k);
         if ((k % 2) == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > (64'sd1 << 31)) begin
         acc = 64'sd1 << 31;
      end
      r = longint'(acc);
      for (int i = 0; i < 4; i++) begin
         r = (r * r + (64'd1 << 30)) >> 31;
      end
      return r;
   endfunction

   function automatic logic [15:0] sigmoid_sample(input int unsigned k);
      longint          v;
      longint unsigned mag;
      longint unsigned den;
      longint unsigned s;
      v = -32768 + longint'(((2 * longint'(k) + 1) * 32768) / SWR_SIGMOID_ENTRIES);
      mag = (v < 0) ? -v : v;
      den = (64'd1 << 31) + neg_exp_q31(mag);
      s = ((64'd1 << 47) + den / 2) / den;
      if (v < 0) begin
         s = 64'd65536 - s;
      end
      if (s > 64'd65535) begin
         s = 64'd65535;
      end
      return s[15:0];
   endfunction

   function automatic longint unsigned activation_of(input logic signed [VAL_W-1:0] gate,
                                                     input logic signed [VAL_W-1:0] up);
      longint          g;
      longint          u;
      longint          idx;
      longint unsigned gmag;
      longint unsigned umag;
      longint unsigned smag;
      longint unsigned act;
      g = gate;
      u = up;
      idx = ((g + 32768) * longint'(SWR_SIGMOID_ENTRIES)) / 65536;
      if (idx > SWR_SIGMOID_ENTRIES - 1) begin
         idx = SWR_SIGMOID_ENTRIES - 1;
      end
      gmag = (g < 0) ? -g : g;
      umag = (u < 0) ? -u : u;
      smag = (gmag * sigmoid_table[idx] + 64'd32768) >> 16;
      act = (smag * umag + 64'd2048) >> 12;
      if (act > ACT_MAX) begin
         act = ACT_MAX;
      end
      return act;
   endfunction

   // Works out the result of one channel and advances the per-token counters.
   function automatic channel_result_type predict_channel(
      input logic signed [VAL_W-1:0] gate,
      input logic signed [VAL_W-1:0] up,
      input logic last);
      channel_result_type res;
      longint unsigned    act;
      longint unsigned    cnt;
      logic               hit;
      act = activation_of(gate, up);
      hit = act > threshold_reg;
      cnt = fired_so_far + hit;
      if (cnt > CNT_MAX) begin
         cnt = CNT_MAX;
      end
      res.abs_activation = act[ACT_W-1:0];
      res.fired = hit;
      res.channel_index = chan_pos[IDX_W-1:0];
      res.fired_count = cnt[CNT_W-1:0];
      res.token_done = last;
      if (last) begin
         chan_pos = 0;
         fired_so_far = 0;
      end else begin
         chan_pos = ((chan_pos + 1) % SWR_MAX_CHANNELS) & IDX_MASK;
         fired_so_far = cnt;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
         $display("%0t: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   function automatic logic signed [VAL_W-1:0] draw_q412();
      logic signed [VAL_W-1:0] v;
      case ($urandom_range(0, 7))
         4: v = 16'($urandom_range(0, 1023)) - 16'sd512;
         5: begin
            case ($urandom_range(0, 4))
               0: v = 16'h8000;
               1: v = 16'h7FFF;
               2: v = 16'h0000;
               3: v = 16'hFFFF;
               default: v = 16'h0001;
            endcase
         end
         6: begin
            v = 16'($urandom_range(16'h7000, 16'h7FFF));
            if ($urandom_range(0, 1) == 1) begin
               v = -v;
            end
         end
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   task automatic offer_channel(input logic signed [VAL_W-1:0] gate,
                                input logic signed [VAL_W-1:0] up,
                                input logic last,
                                input logic typed,
                                input channel_result_type want);
      int                 gap;
      channel_result_type res;
      gap = source_idles ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.gate_value <= gate;
      req_bus.up_value <= up;
      req_bus.last_channel <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      res = predict_channel(gate, up, last);
      expected_results.push_back(typed ? want : res);
   endtask

   // Stops offering and waits until every outstanding request has produced its result.
   task automatic settle_idle();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [ACT_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.eps_threshold <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      threshold_reg = value;
   endtask

   task automatic run_random_tokens(input int items, input int pause_at);
      int   sent;
      int   kind;
      int   len;
      logic lst;
      sent = 0;
      while (sent < items) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            len = 1;
         end else if (kind <= 6) begin
            len = $urandom_range(2, 24);
         end else begin
            len = $urandom_range(25, 60);
         end
         for (int c = 0; c < len && sent < items; c++) begin
            if (kind == 9) begin
               lst = ($urandom_range(0, 3) == 0);
            end else begin
               lst = (c == len - 1);
            end
            offer_channel(draw_q412(), draw_q412(), lst, 1'b0, '0);
            sent++;
            if (sent == pause_at) begin
               settle_idle();
            end
         end
      end
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            int                 gap;
            channel_result_type want;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_bus.abs_activation, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.abs_activation !== want.abs_activation) begin
                  report_mismatch("abs_activation", rsp_bus.abs_activation, want.abs_activation);
               end
               if (rsp_bus.fired !== want.fired) begin
                  report_mismatch("fired", rsp_bus.fired, want.fired);
               end
               if (rsp_bus.channel_index !== want.channel_index) begin
                  report_mismatch("channel_index", rsp_bus.channel_index, want.channel_index);
               end
               if (rsp_bus.fired_count !== want.fired_count) begin
                  report_mismatch("fired_count", rsp_bus.fired_count, want.fired_count);
               end
               if (rsp_bus.token_done !== want.token_done) begin
                  report_mismatch("token_done", rsp_bus.token_done, want.token_done);
               end
            end
            gap = sink_idles ? $urandom_range(0, GAP_MAX) : 0;
            if (hold_sink) begin
               hold_sink = 1'b0;
               gap = HOLD_LEN;
            end
            if (gap > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      logic [ACT_W-1:0] edge_value;
      mismatches = 0;
      source_idles = 1'b1;
      sink_idles = 1'b1;
      hold_sink = 1'b0;
      threshold_reg = '0;
      chan_pos = 0;
      fired_so_far = 0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.gate_value <= '0;
      req_bus.up_value <= '0;
      req_bus.last_channel <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.eps_threshold <= '0;
      for (int k = 0; k < SWR_SIGMOID_ENTRIES; k++) begin
         sigmoid_table[k] = sigmoid_sample(k);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_threshold('0);
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         offer_channel(DIRECTED_ROWS[i].gate, DIRECTED_ROWS[i].up, DIRECTED_ROWS[i].last,
                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
      settle_idle();

      // An activation exactly at the threshold must not fire.
      edge_value = activation_of(16'sh1000, 16'sh1000);
      write_threshold(edge_value);
      offer_channel(16'sh1000, 16'sh1000, 1'b0, 1'b0, '0);
      offer_channel(16'sh1000, 16'sh1010, 1'b0, 1'b0, '0);
      offer_channel(16'sh1000, -16'sh1000, 1'b1, 1'b0, '0);
      settle_idle();

      write_threshold(ACT_W'(ACT_MAX));
      run_random_tokens(250, -1);
      settle_idle();
      write_threshold('0);
      run_random_tokens(250, -1);
      settle_idle();
      write_threshold(ACT_W'($urandom_range(0, 8192)));
      run_random_tokens(400, -1);
      settle_idle();
      write_threshold(ACT_W'($urandom_range(0, ACT_MAX)));
      run_random_tokens(400, -1);
      settle_idle();
      write_threshold(18'd65536);
      run_random_tokens(300, 150);
      settle_idle();

      // The sink stalls for a long stretch while requests keep coming back to back.
      source_idles = 1'b0;
      hold_sink = 1'b1;
      write_threshold(18'd1);
      run_random_tokens(300, -1);
      settle_idle();

      // One longer token in which every channel fires.
      sink_idles = 1'b0;
      write_threshold('0);
      for (int i = 0; i < LONG_LEN; i++) begin
         offer_channel(16'($urandom_range(16'h1000, 16'h7FFF)),
                       ($urandom_range(0, 1) == 1) ? 16'($urandom_range(16'h1000, 16'h7FFF))
                                                  : -16'($urandom_range(16'h1000, 16'h7FFF)),
                       1'b0, 1'b0, '0);
      end
      offer_channel(16'sh4000, 16'sh4000, 1'b1, 1'b0, '0);
      source_idles = 1'b1;
      sink_idles = 1'b1;
      run_random_tokens(20, -1);

      settle_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
